>>> rtl/ntp_pp_pkg.sv
// Shared types, constants and helper functions for the NTP packet parser.
`timescale 1ns / 1ps
`default_nettype none

package ntp_pp_pkg;

    localparam int PACKET_BYTES = 48;
    localparam int POS_W        = $clog2(PACKET_BYTES + 1);
    localparam int REF_OFFSET   = 12;
    localparam int REF_BYTES    = 4;
    localparam int TS_OFFSET    = 24;
    localparam int TS_WORDS     = 6;
    localparam int TS_IDX_W     = $clog2(TS_WORDS);
    localparam int STAMPS       = TS_WORDS / 2;

    localparam logic [2:0]  NTP_VERSION  = 3'd4;
    localparam logic [7:0]  POLL_MAX_EXP = 8'd3;
    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [63:0] NS_PER_SEC64 = 64'd1000000000;

    localparam logic [31:0] ID_AUTH = "AUTH";
    localparam logic [31:0] ID_AUTO = "AUTO";
    localparam logic [31:0] ID_CRYP = "CRYP";
    localparam logic [31:0] ID_DENY = "DENY";
    localparam logic [31:0] ID_RSTR = "RSTR";
    localparam logic [31:0] ID_NKEY = "NKEY";
    localparam logic [31:0] ID_RATE = "RATE";

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_BAD_VERSION = 3'd1,
        STATUS_KOD_DENY    = 3'd2,
        STATUS_KOD_RATE    = 3'd3,
        STATUS_KOD_UNKNOWN = 3'd4,
        STATUS_SHORT       = 3'd5
    } status_t;

    typedef struct packed {
        logic                       short_pkt;
        logic [2:0]                 version;
        logic                       stratum_zero;
        logic [7:0]                 poll_exp;
        logic [31:0]                ref_code;
        logic [TS_WORDS-1:0][31:0]  words;
    } hdr_t;

    typedef struct packed {
        status_t     status;
        logic [61:0] origin_ns;
        logic [61:0] receive_ns;
        logic [61:0] transmit_ns;
        logic [63:0] poll_ns;
    } result_t;

    function automatic status_t kod_status(input logic [31:0] id);
        status_t s;
        begin
            if (id inside {ID_AUTH, ID_AUTO, ID_CRYP, ID_DENY, ID_RSTR, ID_NKEY})
            begin
                s = STATUS_KOD_DENY;
            end
            else if (id == ID_RATE)
            begin
                s = STATUS_KOD_RATE;
            end
            else
            begin
                s = STATUS_KOD_UNKNOWN;
            end
            return s;
        end
    endfunction

    function automatic logic [63:0] poll_to_ns(input logic [7:0] raw);
        logic [8:0]  mag;
        logic [63:0] r;
        begin
            mag = 9'd256 - {1'b0, raw};
            if (!raw[7])
            begin
                if (raw >= POLL_MAX_EXP)
                begin
                    r = '1;
                end
                else
                begin
                    r = NS_PER_SEC64 << raw[1:0];
                end
            end
            else if (mag >= 9'd64)
            begin
                r = '0;
            end
            else
            begin
                r = NS_PER_SEC64 >> mag[5:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/ntp_pp_capture.sv
// Byte counter and header capture registers for the NTP packet parser.
`timescale 1ns / 1ps
`default_nettype none

module ntp_pp_capture (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output logic                   done_valid,
    input  wire logic              done_ready,
    output ntp_pp_pkg::hdr_t       hdr
);
    import ntp_pp_pkg::*;

    logic [POS_W-1:0]               pos_reg,      pos_next;
    logic [2:0]                     version_reg,  version_next;
    logic                           stratum_reg,  stratum_next;
    logic [7:0]                     poll_reg,     poll_next;
    logic [31:0]                    ref_reg,      ref_next;
    logic [TS_WORDS-1:0][31:0]      words_reg,    words_next;
    logic                           done_reg,     done_next;
    logic                           short_reg,    short_next;

    logic                           accept;
    logic                           in_range;
    logic [POS_W-1:0]               pos_after;
    logic [POS_W-1:0]               ts_rel;
    logic [TS_IDX_W-1:0]            widx;

    assign in_ready = !done_reg || done_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = pos_reg < POS_W'(PACKET_BYTES);
    assign pos_after = in_range ? pos_reg + POS_W'(1) : pos_reg;
    assign ts_rel   = pos_reg - POS_W'(TS_OFFSET);
    assign widx     = TS_IDX_W'(ts_rel >> 2);

    always_comb
    begin
        pos_next     = pos_reg;
        version_next = version_reg;
        stratum_next = stratum_reg;
        poll_next    = poll_reg;
        ref_next     = ref_reg;
        words_next   = words_reg;
        short_next   = short_reg;
        done_next    = done_ready ? 1'b0 : done_reg;
        if (accept)
        begin
            if (in_range)
            begin
                if (pos_reg == POS_W'(0))
                begin
                    version_next = in_byte[5:3];
                end
                else if (pos_reg == POS_W'(1))
                begin
                    stratum_next = (in_byte == 8'd0);
                end
                else if (pos_reg == POS_W'(2))
                begin
                    poll_next = in_byte;
                end
                else if (pos_reg >= POS_W'(REF_OFFSET) &&
                         pos_reg < POS_W'(REF_OFFSET + REF_BYTES))
                begin
                    ref_next = {ref_reg[23:0], in_byte};
                end
                else if (pos_reg >= POS_W'(TS_OFFSET))
                begin
                    words_next[widx] = {words_reg[widx][23:0], in_byte};
                end
            end
            if (in_last)
            begin
                pos_next   = '0;
                done_next  = 1'b1;
                short_next = pos_after < POS_W'(PACKET_BYTES);
            end
            else
            begin
                pos_next = pos_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            version_reg <= '0;
            stratum_reg <= 1'b0;
            poll_reg    <= '0;
            ref_reg     <= '0;
            done_reg    <= 1'b0;
            short_reg   <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            version_reg <= version_next;
            stratum_reg <= stratum_next;
            poll_reg    <= poll_next;
            ref_reg     <= ref_next;
            done_reg    <= done_next;
            short_reg   <= short_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    assign done_valid       = done_reg;
    assign hdr.short_pkt    = short_reg;
    assign hdr.version      = version_reg;
    assign hdr.stratum_zero = stratum_reg;
    assign hdr.poll_exp     = poll_reg;
    assign hdr.ref_code     = ref_reg;
    assign hdr.words        = words_reg;

endmodule

`default_nettype wire

>>> rtl/ntp_pp_convert.sv
// Status decision and timestamp multiply stage, with the final nanosecond sums.
`timescale 1ns / 1ps
`default_nettype none

module ntp_pp_convert (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ntp_pp_pkg::hdr_t  hdr,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output ntp_pp_pkg::result_t    res
);
    import ntp_pp_pkg::*;

    logic                     valid_reg;
    status_t                  status_reg,  status_next;
    logic [STAMPS-1:0][61:0]  whole_reg,   whole_next;
    logic [STAMPS-1:0][29:0]  part_reg,    part_next;
    logic [63:0]              poll_reg,    poll_next;
    logic [STAMPS-1:0][61:0]  frac_prod;
    logic [STAMPS-1:0][61:0]  sum;
    logic                     advance;

    assign advance  = !valid_reg || res_ready;
    assign in_ready = advance;

    always_comb
    begin
        if (hdr.short_pkt)
        begin
            status_next = STATUS_SHORT;
        end
        else if (hdr.version != NTP_VERSION)
        begin
            status_next = STATUS_BAD_VERSION;
        end
        else if (hdr.stratum_zero)
        begin
            status_next = kod_status(hdr.ref_code);
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    assign whole_next[0] = 62'(hdr.words[0]) * 62'(NS_PER_SEC);
    assign whole_next[1] = 62'(hdr.words[2]) * 62'(NS_PER_SEC);
    assign whole_next[2] = 62'(hdr.words[4]) * 62'(NS_PER_SEC);
    assign frac_prod[0]  = 62'(hdr.words[1]) * 62'(NS_PER_SEC);
    assign frac_prod[1]  = 62'(hdr.words[3]) * 62'(NS_PER_SEC);
    assign frac_prod[2]  = 62'(hdr.words[5]) * 62'(NS_PER_SEC);
    assign part_next[0]  = frac_prod[0][61:32];
    assign part_next[1]  = frac_prod[1][61:32];
    assign part_next[2]  = frac_prod[2][61:32];
    assign poll_next     = poll_to_ns(hdr.poll_exp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            status_reg <= status_next;
            whole_reg  <= whole_next;
            part_reg   <= part_next;
            poll_reg   <= poll_next;
        end
    end

    assign sum[0] = whole_reg[0] + 62'(part_reg[0]);
    assign sum[1] = whole_reg[1] + 62'(part_reg[1]);
    assign sum[2] = whole_reg[2] + 62'(part_reg[2]);

    always_comb
    begin
        res.status      = status_reg;
        res.origin_ns   = '0;
        res.receive_ns  = '0;
        res.transmit_ns = '0;
        res.poll_ns     = '0;
        if (status_reg == STATUS_OK)
        begin
            res.origin_ns   = sum[0];
            res.receive_ns  = sum[1];
            res.transmit_ns = sum[2];
            res.poll_ns     = poll_reg;
        end
    end

    assign res_valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/ntp_pp_outbuf.sv
// Output register with a skid slot so the upstream ready comes from a flop.
`timescale 1ns / 1ps
`default_nettype none

module ntp_pp_outbuf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ntp_pp_pkg::result_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ntp_pp_pkg::result_t       out_data
);
    import ntp_pp_pkg::*;

    logic     out_valid_reg;
    logic     skid_valid_reg;
    result_t  out_data_reg;
    result_t  skid_data_reg;
    logic     in_fire;
    logic     out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/ntp_packet_parser_top.sv
// Top level of the NTPv4 received-packet parser.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one datagram byte per beat on the slave stream, with tlast on the
// final byte, and returns exactly one result beat per datagram on the master stream.
// It accepts a byte in every cycle while the capture stage is not holding a finished
// header for a stalled multiply stage, and the next datagram may follow directly
// after its last byte. The result passes through the header capture registers, the
// stage that multiplies the six timestamp words by one billion, and the output
// register that takes the sums. A stalled master side fills the output skid slot and
// the multiply stage first and only then holds off input bytes.

module ntp_packet_parser_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte[7:0]
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [255:0]       m_tdata    // status[2:0], origin_ns[64:3], receive_ns[126:65],
                                          // transmit_ns[188:127], poll_ns[252:189], zeros
);
    import ntp_pp_pkg::*;

    hdr_t     hdr;
    logic     done_valid;
    logic     done_ready;
    result_t  conv_res;
    logic     conv_valid;
    logic     conv_ready;
    result_t  res;

    ntp_pp_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .hdr        (hdr)
    );

    ntp_pp_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (done_valid),
        .in_ready   (done_ready),
        .hdr        (hdr),
        .res_valid  (conv_valid),
        .res_ready  (conv_ready),
        .res        (conv_res)
    );

    ntp_pp_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (conv_valid),
        .in_ready   (conv_ready),
        .in_data    (conv_res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    assign m_tdata = {3'b000, res.poll_ns, res.transmit_ns, res.receive_ns,
                      res.origin_ns, res.status};

endmodule

`default_nettype wire

>>> rtl/ntp_packet_parser_checker.sv
// Port-level assertion checker for the NTP packet parser and its bind.
`timescale 1ns / 1ps
`default_nettype none

module ntp_packet_parser_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [255:0]  m_tdata
);
    import ntp_pp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result beat withdrawn while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_fields_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != STATUS_OK) |-> (m_tdata[252:3] == '0))
        else $error("Time fields are not zero on an error status.");

endmodule

bind ntp_packet_parser_top ntp_packet_parser_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking stream testbench for the NTPv4 received-packet parser.
`timescale 1ns / 1ps

module testbench;

    import ntp_pp_pkg::*;

    class ntp_result_tracker;
        int unsigned byte_count;
        logic [2:0]  ver_field;
        bit          zero_stratum;
        logic [7:0]  poll_raw;
        logic [31:0] ref_id;
        logic [31:0] ts_word [TS_WORDS];
        result_t     pending_results [$];
        int          errors;

        function new();
            byte_count   = 0;
            ver_field    = '0;
            zero_stratum = 1'b0;
            poll_raw     = '0;
            ref_id       = '0;
            errors       = 0;
            foreach (ts_word[i])
            begin
                ts_word[i] = '0;
            end
        endfunction

        function logic [61:0] stamp_ns(logic [31:0] secs, logic [31:0] frac);
            logic [63:0] whole;
            logic [63:0] part;
            logic [63:0] sum;
            whole = {32'd0, secs} * NS_PER_SEC64;
            part  = ({32'd0, frac} * NS_PER_SEC64) >> 32;
            sum   = whole + part;
            return sum[61:0];
        endfunction

        function logic [63:0] poll_interval_ns(logic [7:0] raw);
            int p;
            p = int'($signed(raw));
            if (p >= int'(POLL_MAX_EXP))
            begin
                return '1;
            end
            if (p >= 0)
            begin
                return NS_PER_SEC64 << p;
            end
            if (-p >= 64)
            begin
                return '0;
            end
            return NS_PER_SEC64 >> (-p);
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            result_t r;
            int      w;
            if (byte_count < PACKET_BYTES)
            begin
                if (byte_count == 0)
                begin
                    ver_field = b[5:3];
                end
                else if (byte_count == 1)
                begin
                    zero_stratum = (b == 8'd0);
                end
                else if (byte_count == 2)
                begin
                    poll_raw = b;
                end
                else if (byte_count >= REF_OFFSET && byte_count < REF_OFFSET + REF_BYTES)
                begin
                    ref_id = {ref_id[23:0], b};
                end
                else if (byte_count >= TS_OFFSET)
                begin
                    w = (byte_count - TS_OFFSET) / 4;
                    ts_word[w] = {ts_word[w][23:0], b};
                end
                byte_count++;
            end
            if (!last)
            begin
                return;
            end
            r = '0;
            if (byte_count < PACKET_BYTES)
            begin
                r.status = STATUS_SHORT;
            end
            else if (ver_field != NTP_VERSION)
            begin
                r.status = STATUS_BAD_VERSION;
            end
            else if (zero_stratum)
            begin
                if (ref_id == ID_AUTH || ref_id == ID_AUTO || ref_id == ID_CRYP ||
                    ref_id == ID_DENY || ref_id == ID_RSTR || ref_id == ID_NKEY)
                begin
                    r.status = STATUS_KOD_DENY;
                end
                else if (ref_id == ID_RATE)
                begin
                    r.status = STATUS_KOD_RATE;
                end
                else
                begin
                    r.status = STATUS_KOD_UNKNOWN;
                end
            end
            else
            begin
                r.status      = STATUS_OK;
                r.origin_ns   = stamp_ns(ts_word[0], ts_word[1]);
                r.receive_ns  = stamp_ns(ts_word[2], ts_word[3]);
                r.transmit_ns = stamp_ns(ts_word[4], ts_word[5]);
                r.poll_ns     = poll_interval_ns(poll_raw);
            end
            pending_results.push_back(r);
            byte_count = 0;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [255:0] d);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no datagram pending: %0h", d);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 64'(want.status), 64'(d[2:0]));
            compare_field("origin_ns", 64'(want.origin_ns), 64'(d[64:3]));
            compare_field("receive_ns", 64'(want.receive_ns), 64'(d[126:65]));
            compare_field("transmit_ns", 64'(want.transmit_ns), 64'(d[188:127]));
            compare_field("poll_ns", want.poll_ns, d[252:189]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;

    ntp_result_tracker tracker = new();
    logic [7:0]        datagram [$];
    int                bytes_sent;

    ntp_packet_parser_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] v4_byte();
        return {2'($urandom), NTP_VERSION, 3'($urandom)};
    endfunction

    function automatic void build_datagram(int len, logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2, logic [31:0] refid, int ts_fill);
        datagram.delete();
        for (int i = 0; i < PACKET_BYTES; i++)
        begin
            if (i >= TS_OFFSET && ts_fill == 1)
            begin
                datagram.push_back(8'h00);
            end
            else if (i >= TS_OFFSET && ts_fill == 2)
            begin
                datagram.push_back(8'hFF);
            end
            else
            begin
                datagram.push_back(8'($urandom));
            end
        end
        datagram[0] = b0;
        datagram[1] = b1;
        datagram[2] = b2;
        for (int i = 0; i < REF_BYTES; i++)
        begin
            datagram[REF_OFFSET + i] = refid[31 - 8 * i -: 8];
        end
        while (datagram.size() > len)
        begin
            void'(datagram.pop_back());
        end
        while (datagram.size() < len)
        begin
            datagram.push_back(8'($urandom));
        end
    endfunction

    task automatic send_datagram();
        bit burst;
        int gap;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < datagram.size(); i++)
        begin
            gap = burst ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tdata  = datagram[i];
            s_tlast  = (i == datagram.size() - 1);
            do
            begin
                @(posedge clk);
            end
            while (!s_tready);
            tracker.note_byte(s_tdata, s_tlast);
            bytes_sent++;
            @(negedge clk);
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
    endtask

    initial
    begin
        int          stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            tracker.check_result(m_tdata);
        end
    end

    initial
    begin
        #10ms;
        $display("[ntp_packet_parser_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] kod_ids [8];
        logic [7:0]  polls [8];
        int          pick;
        int          len;
        int          p;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [31:0] refid;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        bytes_sent     = 0;
        kod_ids = '{ID_AUTH, ID_AUTO, ID_CRYP, ID_DENY, ID_RSTR, ID_NKEY, ID_RATE, "XKEY"};
        polls   = '{8'h03, 8'h7F, 8'h80, 8'hC0, 8'hC1, 8'hFF, 8'h01, 8'h00};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        build_datagram(1, v4_byte(), 8'd1, 8'd0, ID_AUTH, 0);
        send_datagram();
        build_datagram(PACKET_BYTES - 1, v4_byte(), 8'd1, 8'd0, '0, 0);
        send_datagram();
        build_datagram(PACKET_BYTES, v4_byte(), 8'd1, 8'd0, '0, 1);
        send_datagram();
        build_datagram(PACKET_BYTES, v4_byte(), 8'hFF, 8'd2, '1, 2);
        send_datagram();
        build_datagram(PACKET_BYTES, 8'h1B, 8'd2, 8'd6, '0, 0);
        send_datagram();
        build_datagram(PACKET_BYTES, 8'hFF, 8'd0, 8'd6, ID_RATE, 0);
        send_datagram();
        build_datagram(PACKET_BYTES, 8'h00, 8'd0, 8'd6, ID_DENY, 0);
        send_datagram();
        foreach (kod_ids[i])
        begin
            build_datagram(PACKET_BYTES, v4_byte(), 8'd0, 8'd6, kod_ids[i], 0);
            send_datagram();
        end
        foreach (polls[i])
        begin
            build_datagram(PACKET_BYTES, v4_byte(), 8'd3, polls[i], '0, 0);
            send_datagram();
        end
        build_datagram(63, v4_byte(), 8'd2, 8'hFA, '0, 0);
        send_datagram();

        while (bytes_sent < 1200)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                len = $urandom_range(1, PACKET_BYTES - 1);
            end
            else if (pick < 20)
            begin
                len = $urandom_range(PACKET_BYTES + 1, 63);
            end
            else
            begin
                len = PACKET_BYTES;
            end
            b0 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : v4_byte();
            b1 = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                b2 = 8'($urandom);
            end
            else
            begin
                p  = int'($urandom_range(0, 75)) - 66;
                b2 = p[7:0];
            end
            pick  = $urandom_range(0, 9);
            refid = (pick < 7) ? kod_ids[pick] : 32'($urandom);
            pick  = $urandom_range(0, 19);
            build_datagram(len, b0, b1, b2, refid, (pick < 2) ? pick + 1 : 0);
            send_datagram();
        end

        while (tracker.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
        begin
            $display("[ntp_packet_parser_top] OK");
        end
        else
        begin
            $display("[ntp_packet_parser_top] ERROR");
        end
        $finish;
    end

endmodule
